FILE: src/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude core.
package sem_pkg;

  localparam int PixW    = 8;
  localparam int ChanN   = 3;
  localparam int RgbW    = PixW * ChanN;
  localparam int RowW    = 13;
  localparam int HeightMax = 4096;
  localparam int GradW   = 11;
  localparam int SumW    = 21;

  // Sum of squares at or above this value clamps the magnitude to full scale
  localparam logic [SumW-1:0] MagLimit = SumW'(65281);

  // Register indexes of the configuration port
  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef logic [8:0][PixW-1:0] taps_t;
  typedef logic signed [GradW-1:0] grad_t;

  typedef struct packed {
    logic start;
    taps_t taps;
  } lane_req_t;

  typedef struct packed {
    logic done;
    logic [PixW-1:0] mag;
  } lane_rsp_t;

endpackage

FILE: src/sem_row_mem.sv
// Row buffer memory holding the two previous rows of pixels.
module sem_row_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/sem_lane.sv
// One color lane: Sobel gradients, sum of squares and rounded square root.
module sem_lane (
  input  logic               clk,
  input  logic               rst,
  input  sem_pkg::lane_req_t req,
  output sem_pkg::lane_rsp_t rsp
);
  import sem_pkg::*;

  typedef enum logic [1:0] {L_IDLE, L_SQ, L_ROOT, L_FIN} lstate_t;

  lstate_t           state;
  grad_t             gx;
  grad_t             gy;
  logic [SumW-1:0]   sq;
  logic [PixW-1:0]   root;
  logic [2:0]        bit_idx;
  logic [PixW-1:0]   mag;
  logic              done;

  grad_t             gx_next;
  grad_t             gy_next;
  logic [PixW-1:0]   trial;
  logic [2*PixW-1:0] trial_sq;
  logic [2*PixW-1:0] root_sq;
  logic [SumW-1:0]   root_lim;

  // Gradients from the masked 3x3 window
  always_comb begin
    gx_next = (grad_t'(req.taps[2]) + (grad_t'(req.taps[5]) <<< 1) + grad_t'(req.taps[8]))
            - (grad_t'(req.taps[0]) + (grad_t'(req.taps[3]) <<< 1) + grad_t'(req.taps[6]));
    gy_next = (grad_t'(req.taps[6]) + (grad_t'(req.taps[7]) <<< 1) + grad_t'(req.taps[8]))
            - (grad_t'(req.taps[0]) + (grad_t'(req.taps[1]) <<< 1) + grad_t'(req.taps[2]));
  end

  // Trial bit of the root and rounding bound
  always_comb begin
    trial    = root | (PixW'(1) << bit_idx);
    trial_sq = trial * trial;
    root_sq  = root * root;
    root_lim = SumW'(root_sq) + SumW'(root);
  end

  // Sequence one item: gradients, squares, eight root steps, round
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (req.start) begin
            gx    <= gx_next;
            gy    <= gy_next;
            state <= L_SQ;
          end
        end
        L_SQ: begin
          sq      <= SumW'(gx * gx) + SumW'(gy * gy);
          root    <= '0;
          bit_idx <= 3'd7;
          state   <= L_ROOT;
        end
        L_ROOT: begin
          if (SumW'(trial_sq) <= sq) begin
            root <= trial;
          end
          if (bit_idx == 3'd0) begin
            state <= L_FIN;
          end
          bit_idx <= bit_idx - 3'd1;
        end
        L_FIN: begin
          if (sq >= MagLimit) begin
            mag <= '1;
          end else if (sq > root_lim) begin
            mag <= root + PixW'(1);
          end else begin
            mag <= root;
          end
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.mag  = mag;

endmodule

FILE: src/sobel_edge_magnitude_rgb_core.sv
// Top level of the RGB Sobel edge magnitude core.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  s_      | s_tvalid/s_tready  | s_tdata blue,green,red; s_tuser flush
//  m_      | m_tvalid/m_tready  | m_tdata blue,green,red mag; m_tlast
//  cfg_    | cfg_wr_en          | cfg_addr index, cfg_wdata value
//
// An item that gives a result passes from the calc state through the wait and
// output states before the next item is taken; an item without result goes
// back to idle after the calc state. The span is set by the row memory read,
// the gradient stage and the bit-serial root, eight steps, in each color lane.
// Reset clears the sequencer, counters, window and output valid; row memory
// is not cleared, since every entry is written before a tap inside the frame reads it.
// A stalled output holds the sequencer before the result is loaded.
module sobel_edge_magnitude_rgb_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sem_pkg::RgbW-1:0]      s_tdata,   // blue_in, green_in, red_in
  input  logic                          s_tuser,   // flush
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sem_pkg::RgbW-1:0]      m_tdata,   // blue_mag, green_mag, red_mag
  output logic                          m_tlast,   // frame_end
  input  logic                          cfg_wr_en,
  input  logic                          cfg_addr,
  input  logic [sem_pkg::RowW-1:0]      cfg_wdata
);
  import sem_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = RowW + 1;

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_WAIT, S_OUT} state_t;

  state_t            state;
  logic [10:0]       frame_width;
  logic [RowW-1:0]   frame_height;
  logic [ColW-1:0]   in_column;
  logic [RowW-1:0]   in_row;
  logic [ColW-1:0]   cur_col;
  logic [RgbW-1:0]   pix;
  logic [RgbW-1:0]   wa [3];
  logic [RgbW-1:0]   wb [3];
  logic              fe_hold;

  logic [WW-1:0]     eff_w;
  logic [RowW-1:0]   eff_h;
  logic [ColW-1:0]   col_eff;
  logic [2*RgbW-1:0] mem_rdata;
  logic [RgbW-1:0]   right [3];
  logic              prod_a;
  logic              prod_b;
  logic              produce;
  logic [RowW-1:0]   orow;
  logic [WW-1:0]     ocol;
  logic              m_top, m_bot, m_left, m_right;
  logic              fe;
  logic [WW-1:0]     col_inc;
  logic              load_out;
  logic              lanes_done;

  lane_req_t         req [ChanN];
  lane_rsp_t         rsp [ChanN];

  // Clamp configured size to the supported range
  always_comb begin
    if (frame_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = RowW'(1);
    end else if (32'(frame_height) > HeightMax) begin
      eff_h = RowW'(HeightMax);
    end else begin
      eff_h = frame_height;
    end
    col_eff = (WW'(in_column) >= eff_w) ? '0 : in_column;
  end

  assign s_tready = (state == S_IDLE);

  sem_row_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (ColW),
    .DW    (2 * RgbW)
  ) u_row_mem (
    .clk   (clk),
    .we    (state == S_CALC),
    .waddr (cur_col),
    .wdata ({mem_rdata[RgbW-1:0], pix}),
    .raddr (col_eff),
    .rdata (mem_rdata)
  );

  // Result position, border masks and frame end for this item
  always_comb begin
    right[0] = mem_rdata[2*RgbW-1:RgbW];
    right[1] = mem_rdata[RgbW-1:0];
    right[2] = pix;
    prod_a  = (cur_col == '0) && (in_row >= RowW'(2)) && ((in_row - RowW'(2)) < eff_h);
    prod_b  = (cur_col != '0) && (in_row >= RowW'(1)) && ((in_row - RowW'(1)) < eff_h);
    produce = prod_a || prod_b;
    orow    = prod_a ? (in_row - RowW'(2)) : (in_row - RowW'(1));
    ocol    = prod_a ? (eff_w - WW'(1)) : (WW'(cur_col) - WW'(1));
    m_top   = (orow == '0);
    m_bot   = (HW'(orow) + HW'(1)) >= HW'(eff_h);
    m_left  = (ocol == '0);
    m_right = ((WW + 1)'(ocol) + (WW + 1)'(1)) >= (WW + 1)'(eff_w);
    fe      = ((HW'(orow) + HW'(1)) == HW'(eff_h))
           && (((WW + 1)'(ocol) + (WW + 1)'(1)) == (WW + 1)'(eff_w));
    col_inc = WW'(cur_col) + WW'(1);
  end

  // Build each lane's masked window
  for (genvar ch = 0; ch < ChanN; ch++) begin : g_lane
    always_comb begin
      req[ch].start = (state == S_CALC) && produce;
      for (int r = 0; r < 3; r++) begin
        logic mrow;
        mrow = (r == 0 && m_top) || (r == 2 && m_bot);
        req[ch].taps[r*3]     = (mrow || m_left)  ? '0 : wa[r][ch*PixW +: PixW];
        req[ch].taps[r*3 + 1] = mrow              ? '0 : wb[r][ch*PixW +: PixW];
        req[ch].taps[r*3 + 2] = (mrow || m_right) ? '0 : right[r][ch*PixW +: PixW];
      end
    end

    sem_lane u_lane (
      .clk (clk),
      .rst (rst),
      .req (req[ch]),
      .rsp (rsp[ch])
    );
  end

  assign lanes_done = rsp[0].done && rsp[1].done && rsp[2].done;
  assign load_out   = (state == S_OUT) && (!m_tvalid || m_tready);

  // Sequencer, counters, window and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      frame_width  <= 11'd640;
      frame_height <= RowW'(480);
      in_column    <= '0;
      in_row       <= '0;
      m_tvalid     <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        wa[r] <= '0;
        wb[r] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cur_col <= col_eff;
            pix     <= s_tuser ? '0 : s_tdata;
            state   <= S_CALC;
          end
        end
        S_CALC: begin
          for (int r = 0; r < 3; r++) begin
            wa[r] <= wb[r];
            wb[r] <= right[r];
          end
          fe_hold <= fe;
          if (produce && fe) begin
            in_column <= '0;
            in_row    <= '0;
          end else if (col_inc >= eff_w) begin
            in_column <= '0;
            in_row    <= in_row + RowW'(1);
          end else begin
            in_column <= ColW'(col_inc);
          end
          state <= produce ? S_WAIT : S_IDLE;
        end
        S_WAIT: begin
          if (lanes_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {rsp[2].mag, rsp[1].mag, rsp[0].mag};
            m_tlast  <= fe_hold;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // Register writes restart the frame
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          CfgWidth:  frame_width  <= cfg_wdata[10:0];
          CfgHeight: frame_height <= cfg_wdata;
          default:   frame_width  <= frame_width;
        endcase
        in_column <= '0;
        in_row    <= '0;
      end
    end
  end

endmodule

FILE: src/sem_checker.sv
// Port-level checks for the Sobel edge magnitude core, bound to the top level.
module sem_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [sem_pkg::RgbW-1:0] m_tdata,
  input logic                     m_tlast
);

  // One item in work at a time: busy after each transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in work");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // Reset drops the output
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A new result appears only out of a busy cycle
  a_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without an item in work");

endmodule

bind sobel_edge_magnitude_rgb_core sem_checker u_sem_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
